// ===== rtl/scrp_pkg.sv =====
`timescale 1ns / 1ps
package scrp_pkg;

  localparam int MAX_CASCADES_DEF = 4;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int DATA_W           = 32;
  localparam int TABLE_CASCADES   = 4;
  localparam int CASC_W           = 2;
  localparam int TIDX_W           = 7;
  localparam int WORD_W           = 5;
  localparam int MAT_WORDS        = 16;
  localparam int WORDS_USED       = 19;
  localparam int WORD_DMIN        = 16;
  localparam int WORD_DMAX        = 17;
  localparam int WORD_SPLIT       = 18;
  localparam int DIV_STEPS        = 3;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 3;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_PROBE = 1'b1
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CASCADE_COUNT  = 1'b0,
    CFG_SPLIT_FALLBACK = 1'b1
  } cfg_reg_e;

  // per-pass info that rides along with one cascade transform
  typedef struct packed {
    logic [CASC_W-1:0]        casc;
    logic                     last;
    logic signed [DATA_W-1:0] vd;
    logic signed [DATA_W-1:0] dmin;
    logic signed [DATA_W-1:0] dmax;
    logic signed [DATA_W-1:0] split;
  } meta_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] u;
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] z;
    logic                     in_unit;
    meta_t                    meta;
  } pass_t;

endpackage

// ===== rtl/scrp_div.sv =====
`timescale 1ns / 1ps
module scrp_div import scrp_pkg::*; #(
  parameter int NW    = 48,
  parameter int DW    = 32,
  parameter int SW    = 2,
  parameter int STEPS = DIV_STEPS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] sb_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [SW-1:0] sb_o
);

  localparam int STAGES = (NW + STEPS - 1) / STEPS;
  localparam int PW     = STAGES * STEPS;
  localparam int RW     = DW + 1;

  logic          vld_q [STAGES];
  logic [DW-1:0] rem_q [STAGES];
  logic [PW-1:0] nq_q  [STAGES];
  logic [DW-1:0] den_q [STAGES];
  logic [SW-1:0] sb_q  [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic          vin;
    logic [DW-1:0] rem_in;
    logic [PW-1:0] nq_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] sb_in;
    logic [DW-1:0] rem_nx;
    logic [PW-1:0] nq_nx;

    if (s == 0) begin : g_first
      assign vin    = valid_i;
      assign rem_in = '0;
      assign nq_in  = PW'(num_i);
      assign den_in = den_i;
      assign sb_in  = sb_i;
    end else begin : g_next
      assign vin    = vld_q[s-1];
      assign rem_in = rem_q[s-1];
      assign nq_in  = nq_q[s-1];
      assign den_in = den_q[s-1];
      assign sb_in  = sb_q[s-1];
    end

    // restoring division, quotient bits shift in at the bottom
    always_comb begin
      logic [RW-1:0] r;
      logic [PW-1:0] n;
      r = {1'b0, rem_in};
      n = nq_in;
      for (int i = 0; i < STEPS; i++) begin
        r = {r[DW-1:0], n[PW-1]};
        n = {n[PW-2:0], 1'b0};
        if (r >= {1'b0, den_in}) begin
          r    = r - {1'b0, den_in};
          n[0] = 1'b1;
        end
      end
      rem_nx = r[DW-1:0];
      nq_nx  = n;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_nx;
        nq_q[s]  <= nq_nx;
        den_q[s] <= den_in;
        sb_q[s]  <= sb_in;
      end
    end
  end

  assign valid_o = vld_q[STAGES-1];
  assign quo_o   = nq_q[STAGES-1][NW-1:0];
  assign sb_o    = sb_q[STAGES-1];

endmodule

// ===== rtl/shadow_cascade_receiver_probe_top.sv =====
`timescale 1ns / 1ps
// each probe beat issues n cascade transforms through row read, products, row sums,
//   perspective divide, u/v/z, depth normalize and output register, n = cascade
//   count clamped to 1..min(MAX_CASCADES, 4); throughput: one cascade transform per
//   cycle unless out_stall_i holds a result; probe or load taken once issuer is free
// reset: async active low, clears valid bits, issuer and config
//   (cascade_count 4, split fallback on); table contents are undefined until loaded
module shadow_cascade_receiver_probe_top import scrp_pkg::*; #(
  parameter int MAX_CASCADES = MAX_CASCADES_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     mode_i,
  input  logic [TIDX_W-1:0]        table_index_i,
  input  logic signed [DATA_W-1:0] table_value_i,
  input  logic signed [DATA_W-1:0] world_x_i,
  input  logic signed [DATA_W-1:0] world_y_i,
  input  logic signed [DATA_W-1:0] world_z_i,
  input  logic signed [DATA_W-1:0] view_depth_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [CASC_W-1:0]        cascade_index_o,
  output logic signed [DATA_W-1:0] shadow_u_o,
  output logic signed [DATA_W-1:0] shadow_v_o,
  output logic signed [DATA_W-1:0] receiver_depth_o,
  output logic                     in_bounds_o,
  output logic [FRAC_BITS:0]       normalized_depth_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i
);

  localparam longint ONE     = longint'(1) << FRAC_BITS;
  localparam longint EPS_RAW = ((longint'(10) << FRAC_BITS) + 500000) / 1000000;
  localparam longint EPS     = (EPS_RAW < 1) ? 1 : EPS_RAW;
  localparam int     NCAS    = (MAX_CASCADES < TABLE_CASCADES) ? MAX_CASCADES : TABLE_CASCADES;
  localparam int     QNW     = DATA_W + FRAC_BITS;
  localparam int     NNW     = DATA_W + 1 + FRAC_BITS;
  localparam int     NDW     = DATA_W + 1;
  localparam int     ZSW     = 2 + $bits(meta_t);
  localparam int     NSW     = 2 + $bits(pass_t);

  localparam logic signed [DATA_W-1:0] ONE32  = DATA_W'(ONE);
  localparam logic signed [DATA_W-1:0] HALF32 = DATA_W'(ONE >> 1);
  localparam logic signed [DATA_W:0]   EPS33  = (DATA_W + 1)'(EPS);

  function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return DATA_W'(x);
  endfunction

  function automatic logic [DATA_W-1:0] abs32(input logic signed [DATA_W-1:0] x);
    return x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
  endfunction

  function automatic logic signed [DATA_W-1:0] fix_quo(input logic [QNW-1:0] q,
                                                       input logic neg, input logic zero);
    if (zero) return '0;
    if (!neg) begin
      if (q > QNW'(32'h7FFFFFFF)) return 32'sh7FFFFFFF;
      return $signed(q[DATA_W-1:0]);
    end
    if (q > QNW'(33'h080000000)) return 32'sh80000000;
    return $signed(32'd0 - q[DATA_W-1:0]);
  endfunction

  // ---------------- config ----------------
  logic [CFG_DATA_W-1:0] cnt_q;
  logic                  fb_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CFG_DATA_W'(4);
      fb_q  <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_CASCADE_COUNT:  cnt_q <= cfg_data_i;
        CFG_SPLIT_FALLBACK: fb_q  <= cfg_data_i[0];
      endcase
    end
  end

  // ---------------- issuer ----------------
  logic              en;
  logic              out_valid_q;
  logic              active_q;
  logic [CASC_W-1:0] casc_q;
  logic [CASC_W-1:0] last_q;
  logic [CASC_W-1:0] last_w;
  logic [3:0]        n_w;
  logic              issue_last;
  logic              in_acc, probe_acc, load_acc;
  logic signed [DATA_W-1:0] px_q, py_q, pz_q, vd_q;

  assign en = !out_valid_q || !out_stall_i;

  always_comb begin
    n_w = {1'b0, cnt_q};
    if (n_w == 4'd0) n_w = 4'd1;
    if (n_w > 4'(NCAS)) n_w = 4'(NCAS);
    last_w = CASC_W'(n_w - 4'd1);
  end

  assign issue_last = active_q && (casc_q == last_q);
  assign in_stall_o = !en || (active_q && !issue_last);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign probe_acc  = in_acc && (mode_e'(mode_i) == MODE_PROBE);
  assign load_acc   = in_acc && (mode_e'(mode_i) == MODE_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      casc_q   <= '0;
      last_q   <= '0;
    end else begin
      if (en && active_q) begin
        casc_q <= casc_q + 1'b1;
        if (issue_last) active_q <= 1'b0;
      end
      if (probe_acc) begin
        active_q <= 1'b1;
        casc_q   <= '0;
        last_q   <= last_w;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (probe_acc) begin
      px_q <= world_x_i;
      py_q <= world_y_i;
      pz_q <= world_z_i;
      vd_q <= view_depth_i;
    end
  end

  // ---------------- cascade table, one row per cascade ----------------
  logic [DATA_W-1:0] tbl_q [TABLE_CASCADES][WORDS_USED];

  always_ff @(posedge clk_i) begin
    if (load_acc && (table_index_i[WORD_W-1:0] < WORD_W'(WORDS_USED))) begin
      tbl_q[table_index_i[TIDX_W-1:WORD_W]][table_index_i[WORD_W-1:0]] <= table_value_i;
    end
  end

  // ---------------- stage 1: row read ----------------
  logic                     v1_q;
  meta_t                    meta1_q;
  logic signed [DATA_W-1:0] m1_q [MAT_WORDS];
  logic signed [DATA_W-1:0] p1_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= active_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int w = 0; w < MAT_WORDS; w++) m1_q[w] <= tbl_q[casc_q][w];
      meta1_q.casc  <= casc_q;
      meta1_q.last  <= issue_last;
      meta1_q.vd    <= vd_q;
      meta1_q.dmin  <= tbl_q[casc_q][WORD_DMIN];
      meta1_q.dmax  <= tbl_q[casc_q][WORD_DMAX];
      meta1_q.split <= tbl_q[casc_q][WORD_SPLIT];
      p1_q[0] <= px_q;
      p1_q[1] <= py_q;
      p1_q[2] <= pz_q;
    end
  end

  // ---------------- stage 2: products ----------------
  logic                     v2_q;
  meta_t                    meta2_q;
  logic signed [63:0]       prod2_q [12];
  logic signed [DATA_W-1:0] madd2_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < 3; k++) prod2_q[r*3+k] <= m1_q[r*4+k] * p1_q[k];
        madd2_q[r] <= m1_q[r*4+3];
      end
      meta2_q <= meta1_q;
    end
  end

  // ---------------- stage 3: row sums ----------------
  logic                     v3_q;
  meta_t                    meta3_q;
  logic signed [DATA_W-1:0] clip3_q [4];
  logic signed [65:0]       acc [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      acc[r] = 66'(prod2_q[r*3+0] >>> FRAC_BITS) + 66'(prod2_q[r*3+1] >>> FRAC_BITS)
             + 66'(prod2_q[r*3+2] >>> FRAC_BITS) + 66'(madd2_q[r]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 4; r++) clip3_q[r] <= sat_acc(acc[r]);
      meta3_q <= meta2_q;
    end
  end

  // ---------------- perspective divide ----------------
  logic [QNW-1:0] num_x, num_y, num_z, qx, qy, qz;
  logic [DATA_W-1:0] den_w;
  logic [1:0]     sbx_in, sby_in, sbx, sby;
  logic [ZSW-1:0] sbz_in, sbz;
  logic           vz;
  meta_t          meta_z;

  assign num_x  = {abs32(clip3_q[0]), {FRAC_BITS{1'b0}}};
  assign num_y  = {abs32(clip3_q[1]), {FRAC_BITS{1'b0}}};
  assign num_z  = {abs32(clip3_q[2]), {FRAC_BITS{1'b0}}};
  assign den_w  = abs32(clip3_q[3]);
  assign sbx_in = {clip3_q[0][DATA_W-1] ^ clip3_q[3][DATA_W-1], clip3_q[0] == '0};
  assign sby_in = {clip3_q[1][DATA_W-1] ^ clip3_q[3][DATA_W-1], clip3_q[1] == '0};
  assign sbz_in = {clip3_q[2][DATA_W-1] ^ clip3_q[3][DATA_W-1], clip3_q[2] == '0, meta3_q};

  scrp_div #(.NW(QNW), .DW(DATA_W), .SW(2), .STEPS(DIV_STEPS)) u_div_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3_q), .num_i(num_x), .den_i(den_w),
    .sb_i(sbx_in), .valid_o(), .quo_o(qx), .sb_o(sbx)
  );

  scrp_div #(.NW(QNW), .DW(DATA_W), .SW(2), .STEPS(DIV_STEPS)) u_div_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3_q), .num_i(num_y), .den_i(den_w),
    .sb_i(sby_in), .valid_o(), .quo_o(qy), .sb_o(sby)
  );

  scrp_div #(.NW(QNW), .DW(DATA_W), .SW(ZSW), .STEPS(DIV_STEPS)) u_div_z (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3_q), .num_i(num_z), .den_i(den_w),
    .sb_i(sbz_in), .valid_o(vz), .quo_o(qz), .sb_o(sbz)
  );

  assign meta_z = sbz[$bits(meta_t)-1:0];

  // ---------------- stage 4: u, v, z ----------------
  logic                     v4_q;
  pass_t                    pass4_q;
  logic signed [DATA_W-1:0] fx, fy, fz, u_w, v_w;

  always_comb begin
    fx  = fix_quo(qx, sbx[1], sbx[0]);
    fy  = fix_quo(qy, sby[1], sby[0]);
    fz  = fix_quo(qz, sbz[ZSW-1], sbz[ZSW-2]);
    u_w = (fx >>> 1) + HALF32;
    v_w = HALF32 - (fy >>> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= vz;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pass4_q.u       <= u_w;
      pass4_q.v       <= v_w;
      pass4_q.z       <= fz;
      pass4_q.in_unit <= (u_w >= 0) && (u_w <= ONE32) && (v_w >= 0) && (v_w <= ONE32)
                         && (fz >= 0) && (fz <= ONE32);
      pass4_q.meta    <= meta_z;
    end
  end

  // ---------------- depth range normalize ----------------
  logic signed [DATA_W:0]   dmin33, span_raw, span, diff;
  logic signed [DATA_W+1:0] dhi;
  logic                     zlo, zhi;
  logic [NNW-1:0]           num_n, qn;
  logic [NSW-1:0]           sbn_in, sbn;
  logic                     vn;
  pass_t                    cur;
  logic [FRAC_BITS:0]       cur_norm;

  always_comb begin
    dmin33   = (DATA_W + 1)'(pass4_q.meta.dmin);
    span_raw = (DATA_W + 1)'(pass4_q.meta.dmax) - dmin33;
    span     = (span_raw < EPS33) ? EPS33 : span_raw;
    dhi      = (DATA_W + 2)'(dmin33) + (DATA_W + 2)'(span);
    zlo      = (DATA_W + 1)'(pass4_q.z) <= dmin33;
    zhi      = (DATA_W + 2)'(pass4_q.z) >= dhi;
    diff     = (DATA_W + 1)'(pass4_q.z) - dmin33;
    num_n    = {diff, {FRAC_BITS{1'b0}}};
    sbn_in   = {zlo, zhi, pass4_q};
  end

  scrp_div #(.NW(NNW), .DW(NDW), .SW(NSW), .STEPS(DIV_STEPS)) u_div_n (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4_q), .num_i(num_n), .den_i(span),
    .sb_i(sbn_in), .valid_o(vn), .quo_o(qn), .sb_o(sbn)
  );

  always_comb begin
    cur = sbn[$bits(pass_t)-1:0];
    if (sbn[NSW-1])      cur_norm = '0;
    else if (sbn[NSW-2]) cur_norm = (FRAC_BITS + 1)'(ONE);
    else                 cur_norm = qn[FRAC_BITS:0];
  end

  // ---------------- collect passes, pick cascade ----------------
  pass_t              slot_q [TABLE_CASCADES];
  logic [FRAC_BITS:0] snorm_q [TABLE_CASCADES];
  pass_t              cp [TABLE_CASCADES];
  logic [FRAC_BITS:0] cn [TABLE_CASCADES];
  logic [CASC_W-1:0]  sel;
  logic               found;

  always_ff @(posedge clk_i) begin
    if (en && vn) begin
      slot_q[cur.meta.casc]  <= cur;
      snorm_q[cur.meta.casc] <= cur_norm;
    end
  end

  always_comb begin
    for (int c = 0; c < TABLE_CASCADES; c++) begin
      if (CASC_W'(c) == cur.meta.casc) begin
        cp[c] = cur;
        cn[c] = cur_norm;
      end else begin
        cp[c] = slot_q[c];
        cn[c] = snorm_q[c];
      end
    end
    // lowest containing cascade wins
    sel   = '0;
    found = 1'b0;
    for (int c = TABLE_CASCADES - 1; c >= 0; c--) begin
      if (c <= cur.meta.casc && cp[c].in_unit) begin
        sel   = CASC_W'(c);
        found = 1'b1;
      end
    end
    if (!found && fb_q) begin
      for (int c = 0; c < TABLE_CASCADES - 1; c++) begin
        if (c < cur.meta.casc && cur.meta.vd > cp[c].meta.split) sel = CASC_W'(c + 1);
      end
    end
  end

  // ---------------- output register ----------------
  logic [CASC_W-1:0]        idx_q;
  logic signed [DATA_W-1:0] ou_q, ov_q, oz_q;
  logic                     oin_q;
  logic [FRAC_BITS:0]       onorm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= vn && cur.meta.last;
  end

  always_ff @(posedge clk_i) begin
    if (en && vn && cur.meta.last) begin
      idx_q   <= sel;
      ou_q    <= cp[sel].u;
      ov_q    <= cp[sel].v;
      oz_q    <= cp[sel].z;
      oin_q   <= cp[sel].in_unit;
      onorm_q <= cn[sel];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign cascade_index_o    = idx_q;
  assign shadow_u_o         = ou_q;
  assign shadow_v_o         = ov_q;
  assign receiver_depth_o   = oz_q;
  assign in_bounds_o        = oin_q;
  assign normalized_depth_o = onorm_q;

endmodule

// ===== rtl/scrp_checker.sv =====
`timescale 1ns / 1ps
module scrp_checker import scrp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [CASC_W-1:0]        cascade_index_o,
  input logic signed [DATA_W-1:0] shadow_u_o,
  input logic signed [DATA_W-1:0] shadow_v_o,
  input logic signed [DATA_W-1:0] receiver_depth_o,
  input logic                     in_bounds_o,
  input logic [FRAC_BITS:0]       normalized_depth_o
);

  localparam logic signed [DATA_W-1:0] ONE32 = DATA_W'(longint'(1) << FRAC_BITS);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cascade_index_o)
      && $stable(shadow_u_o) && $stable(shadow_v_o) && $stable(receiver_depth_o)
      && $stable(in_bounds_o) && $stable(normalized_depth_o))
    else $error("result beat changed while stalled");

  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> normalized_depth_o <= (FRAC_BITS + 1)'(ONE32))
    else $error("normalized depth above one");

  a_bounds_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_bounds_o |-> shadow_u_o >= 0 && shadow_u_o <= ONE32
      && shadow_v_o >= 0 && shadow_v_o <= ONE32
      && receiver_depth_o >= 0 && receiver_depth_o <= ONE32)
    else $error("in-bounds flag with coordinates outside unit range");

endmodule

bind shadow_cascade_receiver_probe_top scrp_checker #(.FRAC_BITS(FRAC_BITS)) u_scrp_checker (.*);
